// ===== rtl/core/jlr_pkg.sv =====
`default_nettype none
package jlr_pkg;

    localparam int QW       = 32;          // Q16.16 value width
    localparam int NW       = 58;          // numerator width of the shared unit
    localparam int DW       = 33;          // divisor width
    localparam int CW       = 6;           // step counter width
    localparam int DivSteps = NW;
    localparam int SqrSteps = 24;

    typedef enum logic [1:0] {
        CFG_RISE_RATE  = 2'd0,
        CFG_FALL_RATE  = 2'd1,
        CFG_RISE_ACCEL = 2'd2,
        CFG_FALL_ACCEL = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic          start;
        logic          sqrt_mode;
        logic [NW-1:0] num;
        logic [DW-1:0] den;
    } t_dsu_req;

    typedef struct packed {
        logic          done;
        logic [NW-1:0] quo;
    } t_dsu_rsp;

    function automatic logic signed [QW-1:0] f_sat33(input logic signed [QW:0] v);
        if (v[QW] != v[QW-1]) begin
            return v[QW] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
        end
        return v[QW-1:0];
    endfunction

    function automatic logic signed [QW-1:0] f_sat66(input logic signed [65:0] v);
        if (v[65:QW-1] != {(67-QW){v[65]}}) begin
            return v[65] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
        end
        return v[QW-1:0];
    endfunction

    // arithmetic shift that rounds toward zero
    function automatic logic signed [65:0] f_trunc_shift(input logic signed [65:0] p,
                                                          input int sh);
        logic signed [65:0] bias;
        bias = p[65] ? ((66'sd1 <<< sh) - 66'sd1) : '0;
        return (p + bias) >>> sh;
    endfunction

    function automatic logic [QW:0] f_abs33(input logic signed [QW:0] v);
        return v[QW] ? (QW+1)'(0) - v : v;
    endfunction

    // signed, saturated value from sign and magnitude
    function automatic logic signed [QW-1:0] f_sat_mag(input logic neg,
                                                       input logic [NW-1:0] q);
        if (!neg) begin
            return (q > NW'(32'h7FFF_FFFF)) ? {1'b0, {(QW-1){1'b1}}} : q[QW-1:0];
        end
        return (q > NW'(32'h8000_0000)) ? {1'b1, {(QW-1){1'b0}}} : QW'(0) - q[QW-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/jlr_in_if.sv =====
`default_nettype none
interface jlr_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] set_point;
    logic [31:0] delta_time;

    modport source (output valid, output set_point, output delta_time, input ready);
    modport sink   (input valid, input set_point, input delta_time, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/jlr_out_if.sv =====
`default_nettype none
interface jlr_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] limited_value;

    modport source (output valid, output limited_value, input ready);
    modport sink   (input valid, input limited_value, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/jerk_limited_ramp_unit.sv =====
// Jerk limited ramp: rate and acceleration limiter on Q16.16 samples.
// The first item and an item with a zero time step go straight to the output;
// any other item runs three 58-step divisions and one 24-step square root
// (skipped with the overshoot bound on a negative argument) in the one shared
// divide/root unit, plus four multiply/compare pairs.
// A new item is taken only in idle, once the last result is in the output
// register; a stalled result holds the block. Synchronous active-low reset clears the state.
`default_nettype none
module jerk_limited_ramp_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    jlr_in_if.sink           i_in,
    jlr_out_if.source        o_out,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data
);
    import jlr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_M1, S_C1, S_M2, S_C2, S_D1, S_D2,
        S_M3, S_C3, S_SQ, S_M4, S_C4, S_D3, S_OUT
    } t_state;

    t_state r_state;

    logic [30:0]          r_rise_rate;
    logic signed [31:0]   r_fall_rate;
    logic [30:0]          r_rise_accel;
    logic signed [31:0]   r_fall_accel;

    logic signed [31:0]   r_lo, r_lor, r_li, r_lir;
    logic [31:0]          r_ldt;
    logic                 r_started;

    logic signed [31:0]   r_sp;
    logic [31:0]          r_dt;
    logic [32:0]          r_tsum;
    logic signed [65:0]   r_prod;
    logic signed [31:0]   r_ause, r_aother;
    logic                 r_ispos, r_isneg;
    logic signed [31:0]   r_rate, r_in_rate, r_in_acc, r_res;
    logic                 r_neg;
    logic                 r_out_valid;
    logic [31:0]          r_out_data;
    t_dsu_req             r_req;
    t_dsu_rsp             dsu_rsp;

    logic signed [32:0]   mul_a, mul_b;
    logic signed [31:0]   t24, pred, rate_a, rate_b, max_out, res_a, res_b;
    logic signed [31:0]   arg, lim_hi, lim_lo, rate_c, rate_d, q_val;
    logic signed [31:0]   rise_rate_s, rise_accel_s;
    logic signed [32:0]   diff_in, diff_out, diff_rate;

    jlr_dsu u_dsu (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (r_req),
        .o_rsp  (dsu_rsp)
    );

    always_comb begin
        rise_rate_s  = {1'b0, r_rise_rate};
        rise_accel_s = {1'b0, r_rise_accel};
        t24   = f_sat66(f_trunc_shift(r_prod, 24));
        pred  = f_sat33(33'(r_lo) + 33'(t24));

        rate_a = f_sat33(33'(r_lor) + 33'(t24));
        rate_b = (rate_a > rise_rate_s) ? rise_rate_s : rate_a;
        if (rate_b < r_fall_rate) begin
            rate_b = r_fall_rate;
        end

        arg    = f_sat66(f_trunc_shift(r_prod, 15));
        lim_hi = f_sat33(33'(r_in_rate) + $signed({9'd0, dsu_rsp.quo[23:0]}));
        lim_lo = f_sat33(33'(r_in_rate) - $signed({9'd0, dsu_rsp.quo[23:0]}));
        rate_c = (r_rate > lim_hi && r_ispos) ? lim_hi : r_rate;
        rate_d = (rate_c < lim_lo && r_isneg) ? lim_lo : rate_c;

        max_out = f_sat33(33'(r_lo) + 33'(t24));
        res_a   = (r_sp > max_out && r_ispos) ? max_out : r_sp;
        res_b   = (res_a < max_out && r_isneg) ? max_out : res_a;

        diff_in   = 33'(r_sp) - 33'(r_li);
        diff_out  = 33'(res_b) - 33'(r_lo);
        q_val     = f_sat_mag(r_neg, dsu_rsp.quo);
        diff_rate = 33'(q_val) - 33'(r_lir);

        case (r_state)
            S_M1: begin
                mul_a = 33'(r_lor);
                mul_b = {1'b0, r_dt};
            end
            S_M2: begin
                mul_a = 33'(r_ause);
                mul_b = {1'b0, r_tsum[32:1]};
            end
            S_M3: begin
                mul_a = 33'(f_sat33(33'(r_sp) - 33'(r_lo)));
                mul_b = 33'(f_sat33(33'(r_in_acc) - 33'(r_aother)));
            end
            S_M4: begin
                mul_a = 33'(r_rate);
                mul_b = {1'b0, r_dt};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_rise_rate  <= 31'h7FFF_FFFF;
            r_fall_rate  <= 32'sh8000_0000;
            r_rise_accel <= 31'h7FFF_FFFF;
            r_fall_accel <= 32'sh8000_0000;
            r_lo         <= '0;
            r_lor        <= '0;
            r_li         <= '0;
            r_lir        <= '0;
            r_ldt        <= '0;
            r_started    <= 1'b0;
            r_out_valid  <= 1'b0;
            r_req        <= '0;
        end else begin
            // launch the shared unit from the states that hand it work
            r_req.start <= (r_state == S_C2) || (r_state == S_C4) ||
                           (r_state == S_C3 && !arg[31]) ||
                           (r_state == S_D1 && dsu_rsp.done);
            if (r_out_valid && o_out.ready && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_RISE_RATE:  r_rise_rate  <= i_cfg_data[30:0];
                    CFG_FALL_RATE:  r_fall_rate  <= i_cfg_data;
                    CFG_RISE_ACCEL: r_rise_accel <= i_cfg_data[30:0];
                    CFG_FALL_ACCEL: r_fall_accel <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_sp <= i_in.set_point;
                        r_dt <= i_in.delta_time;
                        if (!r_started) begin
                            r_started <= 1'b1;
                            r_lo      <= i_in.set_point;
                            r_li      <= i_in.set_point;
                            r_lir     <= '0;
                            r_ldt     <= i_in.delta_time;
                            r_res     <= i_in.set_point;
                            r_state   <= S_OUT;
                        end else if (i_in.delta_time == '0) begin
                            r_res   <= r_lo;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_M1;
                        end
                    end
                end
                S_M1: begin
                    r_prod  <= mul_a * mul_b;
                    r_state <= S_C1;
                end
                S_C1: begin
                    // pick the accel limit that turns toward the set point
                    if (pred > r_sp) begin
                        r_ause   <= r_fall_accel;
                        r_aother <= rise_accel_s;
                        r_ispos  <= (r_fall_accel == rise_accel_s);
                        r_isneg  <= 1'b1;
                    end else begin
                        r_ause   <= rise_accel_s;
                        r_aother <= r_fall_accel;
                        r_ispos  <= 1'b1;
                        r_isneg  <= (rise_accel_s == r_fall_accel);
                    end
                    r_tsum  <= {1'b0, r_dt} + {1'b0, r_ldt};
                    r_state <= S_M2;
                end
                S_M2: begin
                    r_prod  <= mul_a * mul_b;
                    r_state <= S_C2;
                end
                S_C2: begin
                    r_rate          <= rate_b;
                    r_neg           <= diff_in[32];
                    r_req.sqrt_mode <= 1'b0;
                    r_req.num       <= NW'({f_abs33(diff_in), 24'd0});
                    r_req.den       <= {1'b0, r_dt};
                    r_state         <= S_D1;
                end
                S_D1: begin
                    if (dsu_rsp.done) begin
                        r_in_rate       <= q_val;
                        r_neg           <= diff_rate[32];
                        r_req.sqrt_mode <= 1'b0;
                        r_req.num       <= {f_abs33(diff_rate), 25'd0};
                        r_req.den       <= r_tsum;
                        r_state         <= S_D2;
                    end
                end
                S_D2: begin
                    if (dsu_rsp.done) begin
                        r_in_acc <= q_val;
                        r_state  <= S_M3;
                    end
                end
                S_M3: begin
                    r_prod  <= mul_a * mul_b;
                    r_state <= S_C3;
                end
                S_C3: begin
                    // skip the overshoot bound on a negative argument
                    if (!arg[31]) begin
                        r_req.sqrt_mode <= 1'b1;
                        r_req.num       <= {1'b0, arg[30:0], 26'd0};
                        r_req.den       <= '0;
                        r_state         <= S_SQ;
                    end else begin
                        r_state <= S_M4;
                    end
                end
                S_SQ: begin
                    if (dsu_rsp.done) begin
                        r_rate  <= rate_d;
                        r_state <= S_M4;
                    end
                end
                S_M4: begin
                    r_prod  <= mul_a * mul_b;
                    r_state <= S_C4;
                end
                S_C4: begin
                    r_res           <= res_b;
                    r_neg           <= diff_out[32];
                    r_req.sqrt_mode <= 1'b0;
                    r_req.num       <= NW'({f_abs33(diff_out), 24'd0});
                    r_req.den       <= {1'b0, r_dt};
                    r_state         <= S_D3;
                end
                S_D3: begin
                    if (dsu_rsp.done) begin
                        r_lor   <= q_val;
                        r_lo    <= r_res;
                        r_li    <= r_sp;
                        r_lir   <= r_in_rate;
                        r_ldt   <= r_dt;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // hold until the output register is free
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= r_res;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready          = (r_state == S_IDLE);
    assign o_out.valid         = r_out_valid;
    assign o_out.limited_value = r_out_data;

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dsu_rsp.done |-> (r_state == S_D1 || r_state == S_D2 ||
                          r_state == S_D3 || r_state == S_SQ))
        else $error("shared unit finished outside a wait state");

    a_started_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_started |=> r_started)
        else $error("started flag dropped");

    a_out_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && (!r_out_valid || o_out.ready)) |=>
        (r_out_valid && r_state == S_IDLE))
        else $error("result not parked in output register");

endmodule
`default_nettype wire

// ===== rtl/core/jlr_dsu.sv =====
`default_nettype none
module jlr_dsu (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire jlr_pkg::t_dsu_req i_req,
    output jlr_pkg::t_dsu_rsp     o_rsp
);
    import jlr_pkg::*;

    logic [NW-1:0] r_num;
    logic [DW-1:0] r_den;
    logic [DW:0]   r_rem;
    logic [NW-1:0] r_quo;
    logic [CW-1:0] r_cnt;
    logic          r_sqrt;
    logic          r_busy;
    logic          r_done;

    logic [DW:0] rem_sh;
    logic [DW:0] trial;
    logic        ge;

    // one restoring step: bring down one numerator bit (two for the root)
    always_comb begin
        if (r_sqrt) begin
            rem_sh = {r_rem[DW-2:0], r_num[NW-1:NW-2]};
            trial  = {r_quo[DW-2:0], 2'b01};
        end else begin
            rem_sh = {r_rem[DW-1:0], r_num[NW-1]};
            trial  = {1'b0, r_den};
        end
        ge = (rem_sh >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_req.start && r_busy && (r_cnt == CW'(1));
            if (i_req.start) begin
                r_num  <= i_req.num;
                r_den  <= i_req.den;
                r_rem  <= '0;
                r_quo  <= '0;
                r_sqrt <= i_req.sqrt_mode;
                r_cnt  <= i_req.sqrt_mode ? CW'(SqrSteps) : CW'(DivSteps);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= ge ? rem_sh - trial : rem_sh;
                r_num <= r_sqrt ? {r_num[NW-3:0], 2'b00} : {r_num[NW-2:0], 1'b0};
                r_quo <= {r_quo[NW-2:0], ge};
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule
`default_nettype wire
